// ===== rtl/mbrot_pkg.sv =====
package mbrot_pkg;

	// Fixed field widths of the pixel and result channels.
	localparam int PosInW = 12;
	localparam int StepFieldW = 31;
	localparam int OutW = 16;
	localparam int LimitW = 16;
	localparam int PaletteW = 2;

	// Register bus geometry: six 32-bit registers at word addresses.
	localparam int AddrW = 5;
	localparam int DataW = 32;

	// Register map, in word order.
	typedef enum logic [2:0] {
		REG_ORIGIN_REAL = 3'd0,
		REG_ORIGIN_IMAG = 3'd1,
		REG_STEP_REAL   = 3'd2,
		REG_STEP_IMAG   = 3'd3,
		REG_ITER_LIMIT  = 3'd4,
		REG_PALETTE     = 3'd5
	} reg_idx_t;

	// Register reset values: origin at -3.0 - 1.5i, step 2^-10, limit 256.
	localparam logic [DataW-1:0]      OriginRealRst = 32'hD000_0000;
	localparam logic [DataW-1:0]      OriginImagRst = 32'hE800_0000;
	localparam logic [StepFieldW-1:0] StepRst       = 31'h0004_0000;
	localparam logic [LimitW-1:0]     LimitRst      = 16'd256;
	localparam logic [PaletteW-1:0]   PaletteRst    = 2'd0;

	// The palette whose shade counts down from the limit.
	localparam logic [PaletteW-1:0] PalInvert = 2'd1;

	// Microprogram addresses.
	localparam int PcW = 3;
	localparam logic [PcW-1:0] StepFetch = 3'd0;
	localparam logic [PcW-1:0] StepPos   = 3'd1;
	localparam logic [PcW-1:0] StepCLoad = 3'd2;
	localparam logic [PcW-1:0] StepMul   = 3'd3;
	localparam logic [PcW-1:0] StepAdd   = 3'd4;
	localparam logic [PcW-1:0] StepEmit  = 3'd5;
	localparam logic [PcW-1:0] StepLast  = StepEmit;

	// Jump conditions of a control word.
	typedef enum logic [2:0] {
		JC_NONE     = 3'd0,
		JC_ALWAYS   = 3'd1,
		JC_WAIT_IN  = 3'd2,
		JC_STOP     = 3'd3,
		JC_LOOP     = 3'd4,
		JC_OUT_BUSY = 3'd5
	} jcond_t;

	// One microinstruction: datapath enables plus a conditional jump.
	typedef struct packed {
		logic           accept;
		logic           pos_en;
		logic           c_en;
		logic           mul_en;
		logic           z_en;
		logic           out_en;
		jcond_t         jcond;
		logic [PcW-1:0] target;
	} ctrl_word_t;

	// Datapath flags that the jump conditions test.
	typedef struct packed {
		logic in_valid;
		logic stop;
		logic no_escape;
		logic out_busy;
	} seq_status_t;

	// The microprogram. Each iteration is a product step and an add step.
	function automatic ctrl_word_t ucode(input logic [PcW-1:0] pc);
		ctrl_word_t w;
		w = '0;
		w.jcond = JC_NONE;
		w.target = StepFetch;
		unique case (pc)
			StepFetch: begin
				w.accept = 1'b1;
				w.jcond = JC_WAIT_IN;
				w.target = StepFetch;
			end
			StepPos: begin
				w.pos_en = 1'b1;
			end
			StepCLoad: begin
				w.c_en = 1'b1;
			end
			StepMul: begin
				w.mul_en = 1'b1;
				w.jcond = JC_STOP;
				w.target = StepEmit;
			end
			StepAdd: begin
				w.z_en = 1'b1;
				w.jcond = JC_LOOP;
				w.target = StepMul;
			end
			StepEmit: begin
				w.out_en = 1'b1;
				w.jcond = JC_OUT_BUSY;
				w.target = StepEmit;
			end
			default: begin
				w.jcond = JC_ALWAYS;
				w.target = StepFetch;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/mbrot_seq.sv =====
module mbrot_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mbrot_pkg::seq_status_t       status,
	output mbrot_pkg::ctrl_word_t        ctrl
);

	logic [mbrot_pkg::PcW-1:0] pc_q;
	logic [mbrot_pkg::PcW-1:0] pc_next;
	logic                      taken;

	// The control word comes straight out of the program table.
	assign ctrl = mbrot_pkg::ucode(pc_q);

	// Evaluate the jump condition of the current step.
	always_comb begin
		unique case (ctrl.jcond)
			mbrot_pkg::JC_NONE:     taken = 1'b0;
			mbrot_pkg::JC_ALWAYS:   taken = 1'b1;
			mbrot_pkg::JC_WAIT_IN:  taken = !status.in_valid;
			mbrot_pkg::JC_STOP:     taken = status.stop;
			mbrot_pkg::JC_LOOP:     taken = status.no_escape;
			mbrot_pkg::JC_OUT_BUSY: taken = status.out_busy;
			default:                taken = 1'b0;
		endcase
	end

	// Jump or step on; the last step wraps back to the fetch step.
	always_comb begin
		if (taken) begin
			pc_next = ctrl.target;
		end else if (pc_q == mbrot_pkg::StepLast) begin
			pc_next = mbrot_pkg::StepFetch;
		end else begin
			pc_next = pc_q + mbrot_pkg::PcW'(1);
		end
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= mbrot_pkg::StepFetch;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

// ===== rtl/mandelbrot_escape_time_pixel.sv =====
// Escape-time engine for one pixel at a time, driven by a six-step microprogram.
// Each iteration takes a product step and an add step through three
// multipliers, each FRAC_BITS + 4 bits wide on both inputs.
// The next pixel can be taken in the cycle after its result is loaded.
// Reset clears the sequencer and output valid and loads the register defaults.
module mandelbrot_escape_time_pixel #(
	parameter int FRAC_BITS   = 28,
	parameter int COUNT_WIDTH = 16,
	parameter int POS_WIDTH   = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Register bus.
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [mbrot_pkg::AddrW-1:0]          paddr,
	input  logic [mbrot_pkg::DataW-1:0]          pwdata,
	output logic [mbrot_pkg::DataW-1:0]          prdata,
	output logic                                 pready,
	// Pixel channel.
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [mbrot_pkg::PosInW-1:0]         column,
	input  logic [mbrot_pkg::PosInW-1:0]         row,
	// Result channel.
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [mbrot_pkg::OutW-1:0]           escape_count,
	output logic [mbrot_pkg::OutW-1:0]           shade_value,
	output logic [mbrot_pkg::PaletteW-1:0]       palette_used
);

	localparam int ValW   = FRAC_BITS + 4;
	localparam int PosUse = (POS_WIDTH < mbrot_pkg::PosInW) ? POS_WIDTH : mbrot_pkg::PosInW;
	localparam int PprodW = PosUse + mbrot_pkg::StepFieldW;
	localparam int SumW   = PprodW + 2;
	localparam int ProdW  = 2 * ValW;

	localparam logic signed [ValW-1:0] TwoV    = ValW'(64'd2 << FRAC_BITS);
	localparam logic signed [ValW-1:0] NegTwoV = -TwoV;
	localparam logic signed [ValW:0]   FourV   = (ValW + 1)'(64'd4 << FRAC_BITS);

	// Clamp a wide signed value to the point format.
	function automatic logic signed [ValW-1:0] sat_val(input logic signed [SumW-1:0] x);
		logic fits;
		fits = (&x[SumW-1:ValW-1]) || !(|x[SumW-1:ValW-1]);
		if (fits) begin
			return x[ValW-1:0];
		end else if (x[SumW-1]) begin
			return {1'b1, {(ValW - 1){1'b0}}};
		end else begin
			return {1'b0, {(ValW - 1){1'b1}}};
		end
	endfunction

	// Configuration registers.
	logic signed [mbrot_pkg::DataW-1:0]      origin_real_q;
	logic signed [mbrot_pkg::DataW-1:0]      origin_imag_q;
	logic [mbrot_pkg::StepFieldW-1:0]        step_real_q;
	logic [mbrot_pkg::StepFieldW-1:0]        step_imag_q;
	logic [mbrot_pkg::LimitW-1:0]            iteration_limit_q;
	logic [mbrot_pkg::PaletteW-1:0]          palette_q;
	mbrot_pkg::reg_idx_t                     reg_idx;
	logic                                    cfg_wr;

	// Sequencer interface.
	mbrot_pkg::ctrl_word_t                   ctrl;
	mbrot_pkg::seq_status_t                  status;

	// Datapath.
	logic [PosUse-1:0]                       col_q;
	logic [PosUse-1:0]                       row_q;
	logic [PprodW-1:0]                       pos_re_q;
	logic [PprodW-1:0]                       pos_im_q;
	logic signed [SumW-1:0]                  cr_sum_w;
	logic signed [SumW-1:0]                  ci_sum_w;
	logic signed [ValW-1:0]                  cr_q;
	logic signed [ValW-1:0]                  ci_q;
	logic signed [ValW-1:0]                  zx_q;
	logic signed [ValW-1:0]                  zy_q;
	logic signed [ProdW-1:0]                 pxx_w;
	logic signed [ProdW-1:0]                 pyy_w;
	logic signed [ProdW-1:0]                 pxy_w;
	logic signed [ValW-1:0]                  sqx_q;
	logic signed [ValW-1:0]                  sqy_q;
	logic signed [ValW-1:0]                  cross_q;
	logic signed [ValW:0]                    sq_sum_w;
	logic signed [ValW+1:0]                  zx_sum_w;
	logic signed [ValW:0]                    zy_sum_w;
	logic [COUNT_WIDTH-1:0]                  count_q;
	logic [COUNT_WIDTH-1:0]                  limit_w;
	logic [COUNT_WIDTH-1:0]                  shade_w;
	logic                                    big_w;
	logic                                    escape_w;
	logic                                    in_xfer;
	logic                                    out_busy;
	logic                                    out_load;

	// Output register.
	logic                                    out_valid_q;
	logic [mbrot_pkg::OutW-1:0]              escape_count_q;
	logic [mbrot_pkg::OutW-1:0]              shade_value_q;
	logic [mbrot_pkg::PaletteW-1:0]          palette_used_q;

	// Register writes complete in the access phase; the bus never waits.
	assign pready  = 1'b1;
	assign reg_idx = mbrot_pkg::reg_idx_t'(paddr[mbrot_pkg::AddrW-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_real_q     <= mbrot_pkg::OriginRealRst;
			origin_imag_q     <= mbrot_pkg::OriginImagRst;
			step_real_q       <= mbrot_pkg::StepRst;
			step_imag_q       <= mbrot_pkg::StepRst;
			iteration_limit_q <= mbrot_pkg::LimitRst;
			palette_q         <= mbrot_pkg::PaletteRst;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				mbrot_pkg::REG_ORIGIN_REAL: origin_real_q <= pwdata;
				mbrot_pkg::REG_ORIGIN_IMAG: origin_imag_q <= pwdata;
				mbrot_pkg::REG_STEP_REAL:   step_real_q <= pwdata[mbrot_pkg::StepFieldW-1:0];
				mbrot_pkg::REG_STEP_IMAG:   step_imag_q <= pwdata[mbrot_pkg::StepFieldW-1:0];
				mbrot_pkg::REG_ITER_LIMIT:  iteration_limit_q <= pwdata[mbrot_pkg::LimitW-1:0];
				mbrot_pkg::REG_PALETTE:     palette_q <= pwdata[mbrot_pkg::PaletteW-1:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (reg_idx)
			mbrot_pkg::REG_ORIGIN_REAL: prdata = origin_real_q;
			mbrot_pkg::REG_ORIGIN_IMAG: prdata = origin_imag_q;
			mbrot_pkg::REG_STEP_REAL:   prdata = mbrot_pkg::DataW'(step_real_q);
			mbrot_pkg::REG_STEP_IMAG:   prdata = mbrot_pkg::DataW'(step_imag_q);
			mbrot_pkg::REG_ITER_LIMIT:  prdata = mbrot_pkg::DataW'(iteration_limit_q);
			mbrot_pkg::REG_PALETTE:     prdata = mbrot_pkg::DataW'(palette_q);
			default:                    prdata = '0;
		endcase
	end

	// Microprogram sequencer.
	mbrot_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	// Pixel transfers are only taken in the fetch step.
	assign in_stall = !ctrl.accept;
	assign in_xfer  = in_valid && !in_stall;

	// Point position: origin plus position times step, exact then clamped.
	assign cr_sum_w = SumW'(origin_real_q) + SumW'(pos_re_q);
	assign ci_sum_w = SumW'(origin_imag_q) + SumW'(pos_im_q);

	// Three products of the current z.
	assign pxx_w = zx_q * zx_q;
	assign pyy_w = zy_q * zy_q;
	assign pxy_w = zx_q * zy_q;

	// Escape tests: magnitude of either part before the products, then |z|^2.
	assign big_w    = (zx_q >= TwoV) || (zx_q <= NegTwoV) || (zy_q >= TwoV) || (zy_q <= NegTwoV);
	assign sq_sum_w = sqx_q + sqy_q;
	assign escape_w = sq_sum_w >= FourV;

	// Next z from the registered products.
	assign zx_sum_w = sqx_q - sqy_q + cr_q;
	assign zy_sum_w = cross_q + ci_q;

	assign limit_w = COUNT_WIDTH'(iteration_limit_q);
	assign shade_w = (palette_q == mbrot_pkg::PalInvert) ? (limit_w - count_q) : count_q;

	// Flags for the jump conditions.
	assign out_busy = out_valid_q && out_stall;
	assign out_load = ctrl.out_en && !out_busy;

	assign status.in_valid  = in_valid;
	assign status.stop      = (count_q >= limit_w) || big_w;
	assign status.no_escape = !escape_w;
	assign status.out_busy  = out_busy;

	// Datapath registers, each loaded by its control word enable.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			col_q <= column[PosUse-1:0];
			row_q <= row[PosUse-1:0];
		end
		if (ctrl.pos_en) begin
			pos_re_q <= col_q * step_real_q;
			pos_im_q <= row_q * step_imag_q;
		end
		if (ctrl.c_en) begin
			cr_q    <= sat_val(cr_sum_w);
			ci_q    <= sat_val(ci_sum_w);
			zx_q    <= '0;
			zy_q    <= '0;
			count_q <= '0;
		end else if (ctrl.z_en && !escape_w) begin
			zx_q    <= sat_val(SumW'(zx_sum_w));
			zy_q    <= sat_val(SumW'(zy_sum_w));
			count_q <= count_q + COUNT_WIDTH'(1);
		end
		// Squares truncated on their own, cross term scaled by two.
		if (ctrl.mul_en) begin
			sqx_q   <= pxx_w[FRAC_BITS +: ValW];
			sqy_q   <= pyy_w[FRAC_BITS +: ValW];
			cross_q <= pxy_w[FRAC_BITS - 1 +: ValW];
		end
		if (out_load) begin
			escape_count_q <= mbrot_pkg::OutW'(count_q);
			shade_value_q  <= mbrot_pkg::OutW'(shade_w);
			palette_used_q <= palette_q;
		end
	end

	// Result valid: set on load, cleared once the transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign escape_count = escape_count_q;
	assign shade_value  = shade_value_q;
	assign palette_used = palette_used_q;

endmodule

// ===== rtl/mbrot_checker.sv =====
module mbrot_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [mbrot_pkg::OutW-1:0]         escape_count,
	input logic [mbrot_pkg::OutW-1:0]         shade_value,
	input logic [mbrot_pkg::PaletteW-1:0]     palette_used
);

	// A stalled result stays and keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(escape_count)
			&& $stable(shade_value) && $stable(palette_used))
		else $error("result changed while stalled");

	// Outside the inverted palette the shade is the count itself.
	a_shade: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && palette_used != mbrot_pkg::PalInvert |-> shade_value == escape_count)
		else $error("shade differs from count");

	// One pixel at a time: a taken pixel closes the input until its result.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after a transfer");

	// A result only appears after the input has been closed for the iteration.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall) && $past(in_stall, 2))
		else $error("result appeared while input was open");

endmodule

bind mandelbrot_escape_time_pixel mbrot_checker u_mbrot_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	// Channel and bus widths taken from the package.
	localparam int PosInW = mbrot_pkg::PosInW;
	localparam int StepFieldW = mbrot_pkg::StepFieldW;
	localparam int OutW = mbrot_pkg::OutW;
	localparam int LimitW = mbrot_pkg::LimitW;
	localparam int PaletteW = mbrot_pkg::PaletteW;
	localparam int AddrW = mbrot_pkg::AddrW;
	localparam int DataW = mbrot_pkg::DataW;

	localparam int FracBits = 28;
	localparam longint QMax = (longint'(1) << (FracBits + 3)) - 1;
	localparam longint QMin = -QMax - 1;
	localparam longint Two = longint'(2) << FracBits;
	localparam longint Four = longint'(4) << FracBits;

	// Palette codes besides the inverted one from the package.
	localparam logic [PaletteW-1:0] PalGray = 2'd0;
	localparam logic [PaletteW-1:0] PalGreenBlue = 2'd2;
	localparam logic [PaletteW-1:0] PalSpare = 2'd3;

	// First register index with no register behind it.
	localparam logic [2:0] RegFirstHole = 3'd6;

	localparam int PosMax = (1 << PosInW) - 1;
	localparam int Phases = 12;
	localparam int PhaseItems = 94;
	localparam int HoldPhase = 2;
	localparam int PausePhase = 4;
	localparam int LongHold = 400;
	localparam int SettleCycles = 4;
	localparam int TrailCycles = 12;
	localparam int QuietLimit = 600000;
	localparam int MaxShown = 10;

	typedef struct packed {
		logic [OutW-1:0]     count;
		logic [OutW-1:0]     shade;
		logic [PaletteW-1:0] palette;
	} pixel_result_t;

	// Raw words written to the six registers; step, limit and palette keep only their low bits.
	typedef struct packed {
		logic [DataW-1:0] origin_re;
		logic [DataW-1:0] origin_im;
		logic [DataW-1:0] step_re;
		logic [DataW-1:0] step_im;
		logic [DataW-1:0] limit;
		logic [DataW-1:0] palette;
	} view_t;

	typedef struct packed {
		view_t             view;
		logic [PosInW-1:0] col;
		logic [PosInW-1:0] rw;
		logic              typed;
		pixel_result_t     want;
	} pixel_case_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata;
	logic [DataW-1:0] prdata;
	logic pready;
	logic in_valid, in_stall;
	logic [PosInW-1:0] column, row;
	logic out_valid, out_stall;
	logic [OutW-1:0] escape_count, shade_value;
	logic [PaletteW-1:0] palette_used;

	logic [DataW-1:0] reg_shadow [6];
	pixel_result_t pending_pixels [$];
	pixel_case_t directed_cases [$];
	view_t applied;
	logic idle_on;
	int hold_ticket, hold_served;
	int err_count = 0;
	int pixels_sent = 0;
	int results_seen = 0;
	int views_programmed = 0;
	int quiet_cycles = 0;

	mandelbrot_escape_time_pixel #(
		.FRAC_BITS(FracBits),
		.COUNT_WIDTH(LimitW),
		.POS_WIDTH(PosInW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.column(column),
		.row(row),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.escape_count(escape_count),
		.shade_value(shade_value),
		.palette_used(palette_used)
	);

	always #5 clk = ~clk;

	// Report the first few mismatches in full and count the rest.
	task automatic log_mismatch(input string what);
		err_count++;
		if (err_count <= MaxShown) begin
			$display("Mismatch: %s", what);
		end
	endtask

	// Bits that each register keeps.
	function automatic logic [DataW-1:0] reg_mask(input int idx);
		case (idx)
			mbrot_pkg::REG_STEP_REAL, mbrot_pkg::REG_STEP_IMAG:
				return DataW'({StepFieldW{1'b1}});
			mbrot_pkg::REG_ITER_LIMIT: return DataW'({LimitW{1'b1}});
			mbrot_pkg::REG_PALETTE: return DataW'({PaletteW{1'b1}});
			default: return '1;
		endcase
	endfunction

	function automatic longint clamp_q(input longint v);
		if (v > QMax) begin
			return QMax;
		end
		if (v < QMin) begin
			return QMin;
		end
		return v;
	endfunction

	// Escape count, shade and palette for one pixel under the current registers.
	function automatic pixel_result_t escape_time(input logic [PosInW-1:0] col,
			input logic [PosInW-1:0] rw);
		pixel_result_t res;
		longint c_re, c_im, zx, zy, sqx, sqy;
		logic [LimitW-1:0] lim;
		logic [PaletteW-1:0] pal;
		int unsigned n;
		c_re = clamp_q(longint'(signed'(reg_shadow[mbrot_pkg::REG_ORIGIN_REAL]))
			+ longint'(col) * longint'(reg_shadow[mbrot_pkg::REG_STEP_REAL]));
		c_im = clamp_q(longint'(signed'(reg_shadow[mbrot_pkg::REG_ORIGIN_IMAG]))
			+ longint'(rw) * longint'(reg_shadow[mbrot_pkg::REG_STEP_IMAG]));
		lim = reg_shadow[mbrot_pkg::REG_ITER_LIMIT][LimitW-1:0];
		pal = reg_shadow[mbrot_pkg::REG_PALETTE][PaletteW-1:0];
		zx = 0;
		zy = 0;
		n = 0;
		while (n < lim) begin
			// A coordinate of magnitude two or more has already escaped.
			if (zx >= Two || zx <= -Two || zy >= Two || zy <= -Two) begin
				break;
			end
			sqx = (zx * zx) >>> FracBits;
			sqy = (zy * zy) >>> FracBits;
			if (sqx + sqy >= Four) begin
				break;
			end
			// The cross term is doubled by shifting one bit less.
			zy = clamp_q(((zx * zy) >>> (FracBits - 1)) + c_im);
			zx = clamp_q(sqx - sqy + c_re);
			n++;
		end
		res.count = OutW'(n);
		res.shade = (pal == mbrot_pkg::PalInvert) ? OutW'(lim - OutW'(n)) : OutW'(n);
		res.palette = pal;
		return res;
	endfunction

	function automatic view_t make_view(input logic [DataW-1:0] o_re, o_im, s_re, s_im,
			lim, pal);
		view_t v;
		v.origin_re = o_re;
		v.origin_im = o_im;
		v.step_re = s_re;
		v.step_im = s_im;
		v.limit = lim;
		v.palette = pal;
		return v;
	endfunction

	function automatic void add_case(input view_t v, input int col, input int rw,
			input logic typed, input int cnt, input int shade, input logic [PaletteW-1:0] pal);
		pixel_case_t pc;
		pc.view = v;
		pc.col = PosInW'(col);
		pc.rw = PosInW'(rw);
		pc.typed = typed;
		pc.want.count = OutW'(cnt);
		pc.want.shade = OutW'(shade);
		pc.want.palette = pal;
		directed_cases.push_back(pc);
	endfunction

	// One register write: setup cycle, then access cycle. The bus is left selected.
	task automatic reg_write(input logic [2:0] idx, input logic [DataW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx <= mbrot_pkg::REG_PALETTE) begin
			reg_shadow[idx] = data & reg_mask(idx);
		end
	endtask

	task automatic reg_read(input logic [2:0] idx, output logic [DataW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
	endtask

	// Wait for the block to go idle, write every register, then read them all back.
	task automatic program_view(input view_t v);
		logic [DataW-1:0] got;
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_pixels.size() != 0);
		repeat (SettleCycles) @(posedge clk);
		reg_write(mbrot_pkg::REG_ORIGIN_REAL, v.origin_re);
		reg_write(mbrot_pkg::REG_ORIGIN_IMAG, v.origin_im);
		reg_write(mbrot_pkg::REG_STEP_REAL, v.step_re);
		reg_write(mbrot_pkg::REG_STEP_IMAG, v.step_im);
		reg_write(mbrot_pkg::REG_ITER_LIMIT, v.limit);
		reg_write(mbrot_pkg::REG_PALETTE, v.palette);
		// A write to an unmapped index must leave every register alone.
		reg_write(RegFirstHole + 3'($urandom_range(0, 1)), $urandom);
		for (int i = mbrot_pkg::REG_ORIGIN_REAL; i <= mbrot_pkg::REG_PALETTE; i++) begin
			reg_read(3'(i), got);
			if ((got & reg_mask(i)) !== reg_shadow[i]) begin
				log_mismatch($sformatf("register %0d read %h, expected %h", i,
					got & reg_mask(i), reg_shadow[i]));
			end
		end
		psel <= 1'b0;
		penable <= 1'b0;
		applied = v;
		views_programmed++;
	endtask

	// Offer one pixel and hold it until the transfer; valid stays high afterward.
	task automatic offer_pixel(input logic [PosInW-1:0] col, input logic [PosInW-1:0] rw,
			input logic typed, input pixel_result_t typed_res);
		in_valid <= 1'b1;
		column <= col;
		row <= rw;
		do @(posedge clk); while (in_stall);
		if (typed) begin
			pending_pixels.push_back(typed_res);
		end else begin
			pending_pixels.push_back(escape_time(col, rw));
		end
		pixels_sent++;
	endtask

	// Result side: random stall bursts, and one long hold-off on request.
	initial begin : result_side
		int burst;
		out_stall <= 1'b0;
		hold_served <= 0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_ticket) begin
				out_stall <= 1'b1;
				repeat (LongHold) @(posedge clk);
				out_stall <= 1'b0;
				hold_served <= hold_ticket;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 12);
				out_stall <= 1'b1;
				repeat (burst) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Compare each result transfer with the oldest pending prediction.
	always @(posedge clk) begin : check_result
		pixel_result_t want;
		pixel_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.count = escape_count;
			got.shade = shade_value;
			got.palette = palette_used;
			results_seen++;
			if (pending_pixels.size() == 0) begin
				log_mismatch($sformatf("result with no pixel pending: count %0d shade %0d",
					got.count, got.shade));
			end else begin
				want = pending_pixels.pop_front();
				if (got !== want) begin
					log_mismatch($sformatf(
						"result %0d: expected count %0d shade %0d palette %0d, got %0d %0d %0d",
						results_seen, want.count, want.shade, want.palette,
						got.count, got.shade, got.palette));
				end
			end
		end
	end

	// Watchdog on cycles with no transfer on either channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QuietLimit) begin
			$display("Watchdog: no transfer for %0d cycles, %0d results pending",
				quiet_cycles, pending_pixels.size());
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stimulus
		view_t home, v;
		pixel_case_t pc;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		column <= '0;
		row <= '0;
		idle_on <= 1'b1;
		hold_ticket <= 0;
		reg_shadow[mbrot_pkg::REG_ORIGIN_REAL] = mbrot_pkg::OriginRealRst;
		reg_shadow[mbrot_pkg::REG_ORIGIN_IMAG] = mbrot_pkg::OriginImagRst;
		reg_shadow[mbrot_pkg::REG_STEP_REAL] = DataW'(mbrot_pkg::StepRst);
		reg_shadow[mbrot_pkg::REG_STEP_IMAG] = DataW'(mbrot_pkg::StepRst);
		reg_shadow[mbrot_pkg::REG_ITER_LIMIT] = DataW'(mbrot_pkg::LimitRst);
		reg_shadow[mbrot_pkg::REG_PALETTE] = DataW'(mbrot_pkg::PaletteRst);
		home = make_view(mbrot_pkg::OriginRealRst, mbrot_pkg::OriginImagRst,
			DataW'(mbrot_pkg::StepRst), DataW'(mbrot_pkg::StepRst),
			DataW'(mbrot_pkg::LimitRst), DataW'(mbrot_pkg::PaletteRst));
		applied = home;

		// Directed table. With the reset view, pixel (3072, 1536) lands on c = 0.
		add_case(home, 0, 0, 1, 1, 1, PalGray);
		add_case(home, PosMax, PosMax, 1, 1, 1, PalGray);
		add_case(home, 3072, 1536, 1, 256, 256, PalGray);
		v = home;
		v.palette = DataW'(mbrot_pkg::PalInvert);
		add_case(v, 3072, 1536, 1, 256, 0, mbrot_pkg::PalInvert);
		add_case(v, 0, 0, 1, 1, 255, mbrot_pkg::PalInvert);
		// The unused palette shades like gray; upper bits of the word are dropped.
		v.palette = 32'hFFFF_FFFF;
		add_case(v, 3072, 1536, 1, 256, 256, PalSpare);
		v.palette = 32'hFFFF_FFFE;
		add_case(v, 0, 0, 1, 1, 1, PalGreenBlue);
		// Zero limit: no iteration at all.
		v.palette = DataW'(mbrot_pkg::PalInvert);
		v.limit = 32'd0;
		add_case(v, 3072, 1536, 1, 0, 0, mbrot_pkg::PalInvert);
		// Limit written with its upper half set keeps only the low bits.
		v.palette = DataW'(PalGray);
		v.limit = 32'hFFFF_0003;
		add_case(v, 3072, 1536, 1, 3, 3, PalGray);
		// Largest limit at a point inside the set.
		add_case(make_view('0, '0, '0, '0, 32'h0000_FFFF, DataW'(mbrot_pkg::PalInvert)),
			PosMax, PosMax, 1, 65535, 0, mbrot_pkg::PalInvert);
		// Both parts of c saturate high, then sit at the lowest value of the format.
		add_case(make_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1, 256, DataW'(PalGray)),
			PosMax, PosMax, 1, 1, 1, PalGray);
		add_case(make_view(32'h8000_0000, 32'h8000_0000, '0, '0, 256, DataW'(PalGray)), 0, 0,
			1, 1, 1, PalGray);
		// Escape through the sum of squares rather than a single coordinate.
		add_case(make_view(32'h1800_0000, 32'h1800_0000, '0, '0, 256, DataW'(PalGray)),
			1234, 2345, 1, 1, 1, PalGray);
		// c = -2 sits on the edge and is caught by the coordinate test.
		add_case(make_view(32'hE000_0000, '0, '0, '0, 300, DataW'(PalGray)), 0, 0,
			1, 1, 1, PalGray);
		// Slow boundary points and a fine grid near the seahorse valley.
		add_case(home, 2304, 1536, 0, 0, 0, PalGray);
		v = make_view(32'hF400_0000, 32'h0199_999A, 32'h0000_1000, 32'h0000_1000, 1000,
			DataW'(PalGray));
		add_case(v, 100, 200, 0, 0, 0, PalGray);
		add_case(v, PosMax, 0, 0, 0, 0, PalGray);
		add_case(v, 0, PosMax, 0, 0, 0, PalGray);
		add_case(make_view(32'h0400_0000, '0, '0, '0, 500, DataW'(PalGray)), 7, 9,
			0, 0, 0, PalGray);
		v = make_view(mbrot_pkg::OriginRealRst, mbrot_pkg::OriginImagRst, 32'h0010_0000,
			32'h8000_4000, 200, DataW'(PalGreenBlue));
		add_case(v, 700, 500, 0, 0, 0, PalGray);
		add_case(v, 2048, 2048, 0, 0, 0, PalGray);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_cases[i]) begin
			pc = directed_cases[i];
			if (pc.view != applied) begin
				program_view(pc.view);
			end
			offer_pixel(pc.col, pc.rw, pc.typed, pc.want);
		end

		// Random views: mostly framed around the set, some anywhere in the format.
		for (int phase = 0; phase < Phases; phase++) begin
			if ($urandom_range(0, 9) < 8) begin
				v.origin_re = $urandom_range(0, 32'h3000_0000) - 32'h2800_0000;
				v.origin_im = $urandom_range(0, 32'h2000_0000) - 32'h1800_0000;
				v.step_re = $urandom_range(32'h100, 32'h4_0000) | ($urandom & 32'h8000_0000);
				v.step_im = $urandom_range(32'h100, 32'h4_0000) | ($urandom & 32'h8000_0000);
			end else begin
				v.origin_re = $urandom;
				v.origin_im = $urandom;
				v.step_re = $urandom;
				v.step_im = $urandom;
			end
			case ($urandom_range(0, 9))
				0: v.limit = 32'd0;
				1, 2, 3, 4, 5: v.limit = $urandom_range(1, 64);
				6, 7, 8: v.limit = $urandom_range(65, 400);
				default: v.limit = {16'($urandom), 16'($urandom_range(1, 32))};
			endcase
			v.palette = $urandom;
			if (phase == Phases - 1) begin
				idle_on <= 1'b0;
			end
			program_view(v);
			for (int k = 0; k < PhaseItems; k++) begin
				// Long hold-off on the result side while pixels keep coming.
				if (phase == HoldPhase && k == 10) begin
					hold_ticket <= hold_ticket + 1;
				end
				// Let every pending result drain before the next pixel.
				if (phase == PausePhase && k == 40) begin
					in_valid <= 1'b0;
					do @(posedge clk); while (pending_pixels.size() != 0);
				end
				offer_pixel(PosInW'($urandom_range(0, PosMax)),
					PosInW'($urandom_range(0, PosMax)), 1'b0, '0);
				if (idle_on && $urandom_range(0, 5) == 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 12)) @(posedge clk);
				end
			end
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (pending_pixels.size() != 0);
		repeat (TrailCycles) @(posedge clk);

		$display("Run covered %0d pixels and %0d results under %0d register settings,",
			pixels_sent, results_seen, views_programmed + 1);
		$display("including zero and full limits, every palette and saturated points.");
		if (err_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches in total", err_count);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
